// ===== design/vtm_pkg.sv =====
// ----------------------------------------------------------------------------
// vtm_pkg
// Shared types and codes for the virtual timer multiplexer: request and
// response payloads, the slot record kept in the timer bank, and result codes.
// ----------------------------------------------------------------------------
`default_nettype none

package vtm_pkg;

   // Default bank size
   localparam int NUM_TIMERS_DEFAULT = 16;

   // Request commands
   localparam logic CMD_START  = 1'b0;
   localparam logic CMD_EXPIRE = 1'b1;

   // Timer modes
   localparam logic MODE_CONTINUOUS = 1'b0;
   localparam logic MODE_ONE_SHOT   = 1'b1;

   // Response kinds
   localparam logic [1:0] KIND_ACK  = 2'd0;
   localparam logic [1:0] KIND_FIRE = 2'd1;
   localparam logic [1:0] KIND_LOAD = 2'd2;

   // Start status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_ZERO_PER  = 2'd2;

   typedef struct packed {
      logic        command;
      logic        mode;
      logic [31:0] period;
      logic [7:0]  handler_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  status;
      logic [7:0]  fired_handler;
      logic        load_valid;
      logic [31:0] load_value;
      logic        bank_empty;
      logic        last;
   } rsp_type;

   // One entry of the timer bank
   typedef struct packed {
      logic        mode;
      logic [31:0] period;
      logic [31:0] remaining;
      logic [7:0]  handler;
   } slot_entry_type;

endpackage

`default_nettype wire

// ===== design/virtual_timer_multiplexer_unit.sv =====
// ----------------------------------------------------------------------------
// virtual_timer_multiplexer_unit
// Bank of virtual timers sharing one hardware one-shot timer.
// ----------------------------------------------------------------------------
// A start request takes the lowest free slot and returns one acknowledgement;
// when the bank was empty it also asks for the hardware timer to be loaded
// with the period. An expire request subtracts the least remaining count from
// every active slot, returns one fire response per slot that reached zero in
// ascending slot order, then one next-load response (or the empty flag).
// The bank sits in a single-port memory walked by one index under a small
// sequencer, with one shared compare and one subtractor. A request is taken
// only while the sequencer is idle. An expire makes one pipelined pass for the
// minimum, then an update pass in which each active slot needs a memory read
// followed by a write. Stalls on the response side hold the sequencer.
// Responses wait in an output register, so the next request is accepted
// while the last response is still pending.
// ----------------------------------------------------------------------------
`default_nettype none

module virtual_timer_multiplexer_unit
   import vtm_pkg::*;
#(
   parameter int NUM_TIMERS = NUM_TIMERS_DEFAULT
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output      logic    req_ready,
   input  wire req_type req_data,
   output      logic    rsp_valid,
   input  wire logic    rsp_ready,
   output      rsp_type rsp_data
);

   localparam int IDX_W = $clog2(NUM_TIMERS);
   localparam int CNT_W = $clog2(NUM_TIMERS + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_TIMERS - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(NUM_TIMERS);

   // Sequencer states
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_START   = 4'd1;
   localparam logic [3:0] ST_FIND    = 4'd2;
   localparam logic [3:0] ST_EXP     = 4'd3;
   localparam logic [3:0] ST_MIN     = 4'd4;
   localparam logic [3:0] ST_MIN_END = 4'd5;
   localparam logic [3:0] ST_SUB_RD  = 4'd6;
   localparam logic [3:0] ST_SUB_EX  = 4'd7;
   localparam logic [3:0] ST_FINAL   = 4'd8;

   logic [3:0]            state_ff, state_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   req_type               req_ff, req_in;
   logic [NUM_TIMERS-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [31:0]           least_ff, least_in;
   logic                  found_ff, found_in;
   logic [31:0]           next_ff, next_in;
   logic                  next_found_ff, next_found_in;
   logic                  cmp_valid_ff, cmp_valid_in;
   slot_entry_type        rd_entry_ff;
   logic                  rsp_valid_ff;
   rsp_type               rsp_data_ff;

   slot_entry_type        slot_mem [NUM_TIMERS];

   logic                  out_free;
   logic                  emit;
   rsp_type               emit_data;
   logic                  mem_we;
   slot_entry_type        mem_wdata;
   logic [31:0]           cand;
   logic [31:0]           cmp_ref;
   logic                  cmp_less;
   logic                  cand_take;
   logic [31:0]           diff;
   logic                  in_min;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Shared compare and subtract
   assign in_min   = (state_ff == ST_MIN) || (state_ff == ST_MIN_END);
   assign cmp_ref  = in_min ? least_ff : next_ff;
   assign cmp_less = cand < cmp_ref;
   assign diff     = rd_entry_ff.remaining - least_ff;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      req_in        = req_ff;
      valid_in      = valid_ff;
      count_in      = count_ff;
      least_in      = least_ff;
      found_in      = found_ff;
      next_in       = next_ff;
      next_found_in = next_found_ff;
      cmp_valid_in  = (state_ff == ST_MIN) && valid_ff[idx_ff];
      emit          = 1'b0;
      emit_data     = '0;
      mem_we        = 1'b0;
      mem_wdata     = rd_entry_ff;
      cand          = rd_entry_ff.remaining;
      cand_take     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_data;
               idx_in   = '0;
               state_in = (req_data.command == CMD_EXPIRE) ? ST_EXP : ST_START;
            end
         end

         ST_START: begin
            if (req_ff.period == 32'd0) begin
               if (out_free) begin
                  emit                 = 1'b1;
                  emit_data.kind       = KIND_ACK;
                  emit_data.status     = STATUS_ZERO_PER;
                  emit_data.bank_empty = (count_ff == '0);
                  emit_data.last       = 1'b1;
                  state_in             = ST_IDLE;
               end
            end else if (count_ff == FULL_CNT) begin
               if (out_free) begin
                  emit             = 1'b1;
                  emit_data.kind   = KIND_ACK;
                  emit_data.status = STATUS_FULL;
                  emit_data.last   = 1'b1;
                  state_in         = ST_IDLE;
               end
            end else begin
               state_in = ST_FIND;
            end
         end

         // walk to the lowest free slot; one exists since the bank is not full
         ST_FIND: begin
            if (!valid_ff[idx_ff]) begin
               if (out_free) begin
                  mem_we               = 1'b1;
                  mem_wdata.mode       = req_ff.mode;
                  mem_wdata.period     = req_ff.period;
                  mem_wdata.remaining  = req_ff.period;
                  mem_wdata.handler    = req_ff.handler_id;
                  valid_in[idx_ff]     = 1'b1;
                  count_in             = count_ff + CNT_W'(1);
                  emit                 = 1'b1;
                  emit_data.kind       = KIND_ACK;
                  emit_data.status     = STATUS_OK;
                  emit_data.load_valid = (count_ff == '0);
                  emit_data.load_value = (count_ff == '0) ? req_ff.period : 32'd0;
                  emit_data.last       = 1'b1;
                  state_in             = ST_IDLE;
               end
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         ST_EXP: begin
            if (count_ff == '0) begin
               if (out_free) begin
                  emit                 = 1'b1;
                  emit_data.kind       = KIND_LOAD;
                  emit_data.bank_empty = 1'b1;
                  emit_data.last       = 1'b1;
                  state_in             = ST_IDLE;
               end
            end else begin
               found_in = 1'b0;
               idx_in   = '0;
               state_in = ST_MIN;
            end
         end

         // pipelined minimum pass: issue reads here, compare in the cycle after
         ST_MIN: begin
            if (idx_ff == LAST_IDX) begin
               state_in = ST_MIN_END;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         ST_MIN_END: begin
            idx_in        = '0;
            next_found_in = 1'b0;
            state_in      = ST_SUB_RD;
         end

         ST_SUB_RD: begin
            if (valid_ff[idx_ff]) begin
               state_in = ST_SUB_EX;
            end else if (idx_ff == LAST_IDX) begin
               state_in = ST_FINAL;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end

         // subtract, fire on zero, and track the next minimum
         ST_SUB_EX: begin
            if (diff == 32'd0) begin
               if (out_free) begin
                  emit                    = 1'b1;
                  emit_data.kind          = KIND_FIRE;
                  emit_data.fired_handler = rd_entry_ff.handler;
                  if (rd_entry_ff.mode == MODE_CONTINUOUS) begin
                     mem_we              = 1'b1;
                     mem_wdata.remaining = rd_entry_ff.period;
                     cand                = rd_entry_ff.period;
                     cand_take           = 1'b1;
                  end else begin
                     valid_in[idx_ff] = 1'b0;
                     count_in         = count_ff - CNT_W'(1);
                  end
                  if (idx_ff == LAST_IDX) begin
                     state_in = ST_FINAL;
                  end else begin
                     idx_in   = idx_ff + IDX_W'(1);
                     state_in = ST_SUB_RD;
                  end
               end
            end else begin
               mem_we              = 1'b1;
               mem_wdata.remaining = diff;
               cand                = diff;
               cand_take           = 1'b1;
               if (idx_ff == LAST_IDX) begin
                  state_in = ST_FINAL;
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = ST_SUB_RD;
               end
            end
         end

         ST_FINAL: begin
            if (out_free) begin
               emit                 = 1'b1;
               emit_data.kind       = KIND_LOAD;
               emit_data.load_valid = next_found_ff;
               emit_data.load_value = next_found_ff ? next_ff : 32'd0;
               emit_data.bank_empty = !next_found_ff;
               emit_data.last       = 1'b1;
               state_in             = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // minimum of the current counts
      if (in_min && cmp_valid_ff && (!found_ff || cmp_less)) begin
         least_in = cand;
         found_in = 1'b1;
      end

      // minimum of the updated counts
      if (cand_take && (!next_found_ff || cmp_less)) begin
         next_in       = cand;
         next_found_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         count_ff      <= '0;
         found_ff      <= 1'b0;
         next_found_ff <= 1'b0;
         cmp_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         count_ff      <= count_in;
         found_ff      <= found_in;
         next_found_ff <= next_found_in;
         cmp_valid_ff  <= cmp_valid_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      req_ff   <= req_in;
      least_ff <= least_in;
      next_ff  <= next_in;
      if (emit) begin
         rsp_data_ff <= emit_data;
      end
   end

   // Timer bank memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[idx_ff] <= mem_wdata;
      end
      rd_entry_ff <= slot_mem[idx_ff];
   end

endmodule

`default_nettype wire
